/* hdl/http_request_byte_parser_macros.svh */
// Assertion macros used by the HTTP request byte parser top level.
`ifndef HTTP_REQUEST_BYTE_PARSER_MACROS_SVH
`define HTTP_REQUEST_BYTE_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define HRBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define HRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HRBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/hrbp_pkg.sv */
// Shared types, character codes and byte classes of the HTTP request byte parser.
package hrbp_pkg;

	// Width of the body length and the value accumulator.
	localparam int LENGTH_BITS = 31;
	// Fixed width of the content_length port.
	localparam int OUT_LEN_W = 31;
	// Length of the lowercase "content-length" key.
	localparam logic [3:0] KEY_LEN = 4'd14;

	// Byte classes reported on byte_class.
	localparam logic [2:0] CLS_IGNORE = 3'd0;
	localparam logic [2:0] CLS_METHOD = 3'd1;
	localparam logic [2:0] CLS_PATH   = 3'd2;
	localparam logic [2:0] CLS_HEAD   = 3'd3;
	localparam logic [2:0] CLS_BODY   = 3'd4;

	// Character codes.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;

	// Position of the stream: request line, header lines or body.
	typedef enum logic [1:0] {
		SEC_LINE,
		SEC_HEAD,
		SEC_BODY
	} section_t;

	// Progress through one header line.
	typedef enum logic [2:0] {
		PH_KEY,
		PH_SKIP,
		PH_DIGITS,
		PH_STOPPED,
		PH_ERROR,
		PH_OTHER
	} phase_t;

	// Per-line header tracking state.
	typedef struct packed {
		phase_t                   phase;
		logic [3:0]               key_idx;
		logic                     key_mis;
		logic [LENGTH_BITS-1:0]   acc;
	} hdr_t;

	// One result word.
	typedef struct packed {
		logic [7:0]           data;
		logic [2:0]           cls;
		logic                 done;
		logic [OUT_LEN_W-1:0] len;
		logic                 err;
	} result_t;

endpackage

/* hdl/http_request_byte_parser.sv */
// HTTP request byte parser: takes one request byte per word and returns one result word per
// byte, classing it as method, path, header, body or ignored, tracking Content-Length and
// flagging request completion. A new byte is taken every clock cycle while out_ready does
// not stall the result register; each byte passes an input register and then a result
// register, where its result word is held until the consumer takes it.
// The cycle budget is set by the per-byte state update, whose longest path is the header
// value accumulate (one multiply by ten and add, with an overflow check).
module http_request_byte_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [2:0]  byte_class,
	output logic        request_done,
	output logic [30:0] content_length,
	output logic        header_error
);
	import hrbp_pkg::*;
	`include "http_request_byte_parser_macros.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	result_t    res;
	result_t    res_s2;

	// Input register.
	hrbp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Parser state machine, stepped when a word moves into the result register.
	hrbp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.data   (byte_s1),
		.res    (res)
	);

	// Result register.
	hrbp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.valid_s2  (out_valid),
		.res_s2    (res_s2),
		.out_ready (out_ready)
	);

	// Output fields.
	assign out_byte       = res_s2.data;
	assign byte_class     = res_s2.cls;
	assign request_done   = res_s2.done;
	assign content_length = res_s2.len;
	assign header_error   = res_s2.err;

	// Completion only happens on the empty-line LF or on a body byte.
	`HRBP_ASSERT_IMPL(a_done_class, clk, arst_n, out_valid && request_done, byte_class == CLS_IGNORE || byte_class == CLS_BODY, "request_done on a byte that cannot complete a request")
	// A length error is reported only on the LF that closes a header line.
	`HRBP_ASSERT_IMPL(a_err_on_lf, clk, arst_n, out_valid && header_error, byte_class == CLS_IGNORE && out_byte == CH_LF && !request_done, "header_error on a byte other than a line-closing LF")
	// The body is entered only with a nonzero length in force.
	`HRBP_ASSERT_IMPL(a_body_len, clk, arst_n, out_valid && byte_class == CLS_BODY, content_length != '0, "body byte with zero content length")
	// A word held in the input register while the result side stalls is kept intact.
	`HRBP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1), "input stage lost or changed a stalled word")

endmodule

/* hdl/hrbp_in_stage.sv */
// Input register stage: holds one accepted word until the parser takes it.
module hrbp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import hrbp_pkg::*;

	// The stage frees up when empty or when its word moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload register, loaded on acceptance only.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

/* hdl/hrbp_parser.sv */
// Per-byte parser state machine: classifies a byte and updates the request state.
module hrbp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data,
	output hrbp_pkg::result_t res
);
	import hrbp_pkg::*;

	section_t               section_q, section_d;
	logic [2:0]             tok_q, tok_d;
	logic                   cp_q, cp_d;
	logic                   als_q, als_d;
	hdr_t                   hdr_q, hdr_d;
	logic [LENGTH_BITS-1:0] blen_q, blen_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic                   is_space;
	logic [2:0]             cls;
	logic                   done;
	logic                   err;

	// Lowercase characters of the Content-Length key.
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h63;
			4'd1:    r = 8'h6F;
			4'd2:    r = 8'h6E;
			4'd3:    r = 8'h74;
			4'd4:    r = 8'h65;
			4'd5:    r = 8'h6E;
			4'd6:    r = 8'h74;
			4'd7:    r = 8'h2D;
			4'd8:    r = 8'h6C;
			4'd9:    r = 8'h65;
			4'd10:   r = 8'h6E;
			4'd11:   r = 8'h67;
			4'd12:   r = 8'h74;
			4'd13:   r = 8'h68;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// One content character of a header line.
	function automatic hdr_t hdr_step(input hdr_t h, input logic [7:0] c);
		hdr_t                   r;
		logic [7:0]             f;
		logic                   digit;
		logic [LENGTH_BITS+3:0] nx;
		r = h;
		f = (c >= CH_UC_A && c <= CH_UC_Z) ? c + 8'd32 : c;
		digit = (c >= CH_0) && (c <= CH_9);
		nx = ({4'd0, h.acc} << 3) + ({4'd0, h.acc} << 1) + (LENGTH_BITS+4)'(c[3:0]);
		case (h.phase)
			PH_KEY: begin
				if (c == CH_COLON) begin
					r.phase = (!h.key_mis && h.key_idx == KEY_LEN) ? PH_SKIP : PH_OTHER;
				end else if (!h.key_mis) begin
					if (h.key_idx >= KEY_LEN || f != key_char(h.key_idx)) begin
						r.key_mis = 1'b1;
					end else begin
						r.key_idx = h.key_idx + 4'd1;
					end
				end
			end
			PH_SKIP: begin
				if (c == CH_SP || c == CH_TAB) begin
					r = h;
				end else if (digit) begin
					r.acc   = LENGTH_BITS'(c[3:0]);
					r.phase = PH_DIGITS;
				end else begin
					r.phase = PH_ERROR;
				end
			end
			PH_DIGITS: begin
				if (digit) begin
					if (|nx[LENGTH_BITS+3:LENGTH_BITS]) begin
						r.phase = PH_ERROR;
					end else begin
						r.acc = nx[LENGTH_BITS-1:0];
					end
				end else begin
					r.phase = PH_STOPPED;
				end
			end
			default: begin
				r = h;
			end
		endcase
		return r;
	endfunction

	// Request-line whitespace.
	assign is_space = (data == CH_SP) || (data == CH_TAB) || (data == CH_LF) ||
	                  (data == CH_VT) || (data == CH_FF) || (data == CH_CR);
	assign rem_dec = (rem_q != '0) ? rem_q - LENGTH_BITS'(1) : rem_q;

	// Next state and result for the current byte.
	always_comb begin
		section_d = section_q;
		tok_d     = tok_q;
		cp_d      = cp_q;
		als_d     = als_q;
		hdr_d     = hdr_q;
		blen_d    = blen_q;
		rem_d     = rem_q;
		cls       = CLS_IGNORE;
		done      = 1'b0;
		err       = 1'b0;
		case (section_q)
			SEC_BODY: begin
				cls   = CLS_BODY;
				rem_d = rem_dec;
				done  = (rem_dec == '0);
			end
			SEC_HEAD: begin
				if (cp_q && data == CH_LF) begin
					if (als_q) begin
						cp_d = 1'b0;
						if (blen_q != '0) begin
							section_d = SEC_BODY;
							rem_d     = blen_q;
						end else begin
							done = 1'b1;
						end
					end else begin
						if (hdr_q.phase == PH_DIGITS || hdr_q.phase == PH_STOPPED) begin
							blen_d = hdr_q.acc;
						end else if (hdr_q.phase == PH_SKIP || hdr_q.phase == PH_ERROR) begin
							err = 1'b1;
						end
						cp_d  = 1'b0;
						als_d = 1'b1;
						hdr_d = '{phase: PH_KEY, key_idx: 4'd0, key_mis: 1'b0, acc: '0};
					end
				end else begin
					// A pending CR not followed by LF counts as line text.
					if (cp_q) begin
						hdr_d = hdr_step(hdr_q, CH_CR);
						als_d = 1'b0;
					end
					cp_d = 1'b0;
					if (data == CH_CR) begin
						cp_d = 1'b1;
					end else begin
						hdr_d = hdr_step(hdr_d, data);
						als_d = 1'b0;
						cls   = CLS_HEAD;
					end
				end
			end
			default: begin
				if (cp_q && data == CH_LF) begin
					section_d = SEC_HEAD;
					tok_d     = 3'd0;
					cp_d      = 1'b0;
					als_d     = 1'b1;
					hdr_d     = '{phase: PH_KEY, key_idx: 4'd0, key_mis: 1'b0, acc: '0};
				end else begin
					cp_d = (data == CH_CR);
					if (is_space) begin
						if (tok_q == 3'd1) begin
							tok_d = 3'd2;
						end else if (tok_q == 3'd3) begin
							tok_d = 3'd4;
						end
					end else if (tok_q <= 3'd1) begin
						tok_d = 3'd1;
						cls   = CLS_METHOD;
					end else if (tok_q <= 3'd3) begin
						tok_d = 3'd3;
						cls   = CLS_PATH;
					end
				end
			end
		endcase
	end

	// Result word; the length shown is the one in force before any restart.
	assign res = '{data: data, cls: cls, done: done, len: OUT_LEN_W'(blen_d), err: err};

	// State registers; completion of a request returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q <= SEC_LINE;
			tok_q     <= 3'd0;
			cp_q      <= 1'b0;
			als_q     <= 1'b1;
			hdr_q     <= '{phase: PH_KEY, key_idx: 4'd0, key_mis: 1'b0, acc: '0};
			blen_q    <= '0;
			rem_q     <= '0;
		end else if (step) begin
			if (done) begin
				section_q <= SEC_LINE;
				tok_q     <= 3'd0;
				cp_q      <= 1'b0;
				als_q     <= 1'b1;
				hdr_q     <= '{phase: PH_KEY, key_idx: 4'd0, key_mis: 1'b0, acc: '0};
				blen_q    <= '0;
				rem_q     <= '0;
			end else begin
				section_q <= section_d;
				tok_q     <= tok_d;
				cp_q      <= cp_d;
				als_q     <= als_d;
				hdr_q     <= hdr_d;
				blen_q    <= blen_d;
				rem_q     <= rem_d;
			end
		end
	end

endmodule

/* hdl/hrbp_out_stage.sv */
// Result register stage: holds one result word until the consumer takes it.
module hrbp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  hrbp_pkg::result_t res,
	output logic              advance,
	output logic              valid_s2,
	output hrbp_pkg::result_t res_s2,
	input  logic              out_ready
);
	import hrbp_pkg::*;

	// The register takes a new word when empty or when its word leaves.
	assign advance = !valid_s2 || out_ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule
